// ----- hdl/vrfc_pkg.sv -----
// Shared types, codes and helpers of the frame store fill and copy engine.
package vrfc_pkg;

  // Operation codes carried in the kind field.
  typedef enum logic [1:0] {
    KIND_FILL  = 2'd0,
    KIND_COPY  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_WRITE = 2'd3
  } kind_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_CP_RD,
    ST_CP_RDW,
    ST_CP_WR,
    ST_CP_WRW,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_DONE
  } state_t;

  // Configuration register indexes.
  localparam logic CFG_FORCE_MASK = 1'b0;
  localparam logic CFG_CHECK_MASK = 1'b1;

  // Pixel mask bit position.
  localparam int MASK_BIT = 15;

  // Fill alignment: x is aligned down to 16, width is rounded up to 16.
  localparam logic [9:0]  FILL_ALIGN_MASK = 10'h3F0;
  localparam logic [10:0] FILL_ROUND      = 11'h00F;

  // Access strobes towards the frame store.
  typedef struct packed {
    logic rd;
    logic wr;
  } store_ctl_t;

  // Keep the top five bits of each colour channel; bit 15 stays clear.
  function automatic logic [15:0] fill_pixel(input logic [23:0] color);
    fill_pixel = {1'b0, color[23:19], color[15:11], color[7:3]};
  endfunction

endpackage

// ----- hdl/vrfc_store.sv -----
// Frame store memory with one registered read port and one write port.
module vrfc_store import vrfc_pkg::*; #(
  parameter int STORE_WIDTH  = 1024,
  parameter int STORE_HEIGHT = 512
) (
  input  logic                            clk,
  input  store_ctl_t                      ctl,
  input  logic [$clog2(STORE_WIDTH)-1:0]  rd_x,
  input  logic [$clog2(STORE_HEIGHT)-1:0] rd_y,
  input  logic [$clog2(STORE_WIDTH)-1:0]  wr_x,
  input  logic [$clog2(STORE_HEIGHT)-1:0] wr_y,
  input  logic [15:0]                     wr_data,
  output logic [15:0]                     rd_data
);

  localparam int DEPTH = STORE_WIDTH * STORE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [15:0]   mem [DEPTH];
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // Row-major addressing of the coordinate pairs.
  assign rd_addr = AW'(rd_y) * AW'(STORE_WIDTH) + AW'(rd_x);
  assign wr_addr = AW'(wr_y) * AW'(STORE_WIDTH) + AW'(wr_x);

  // Read-first memory: a read sees the contents before a same-cycle write.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/vram_rect_fill_copy_engine_unit.sv -----
// Top level of the frame store fill and copy engine: sequencer, chunk buffer and result register.
//
//   Channel  Direction  Handshake            Payload
//   cfg      in         cfg_write            cfg_index, cfg_data
//   in       in         in_valid / in_stall  kind, src_x, src_y, dst_x, dst_y, rect_width,
//                                            rect_height, fill_color, pixel_value
//   out      out        out_valid / out_stall read_value, op_done
//
// A fill writes one pixel per cycle across every row of the rounded width.
// A copy reads each chunk of up to CHUNK_PIXELS pixels into the chunk buffer and then
// writes it back, as the frame store has a single read port and a single write port.
// Pixel read and write use one access state each; a stalled output holds the sequencer in DONE.
// Reset clears control state only; the frame store and chunk buffer are undefined until written.
module vram_rect_fill_copy_engine_unit import vrfc_pkg::*; #(
  parameter int STORE_WIDTH  = 1024,
  parameter int STORE_HEIGHT = 512,
  parameter int CHUNK_PIXELS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [9:0]  src_x,
  input  logic [9:0]  src_y,
  input  logic [9:0]  dst_x,
  input  logic [9:0]  dst_y,
  input  logic [9:0]  rect_width,
  input  logic [8:0]  rect_height,
  input  logic [23:0] fill_color,
  input  logic [15:0] pixel_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] read_value,
  output logic        op_done
);

  localparam int XW  = $clog2(STORE_WIDTH);
  localparam int YW  = $clog2(STORE_HEIGHT);
  localparam int LW  = $clog2(STORE_WIDTH + 1024);
  localparam int HW  = $clog2(STORE_HEIGHT + 512);
  localparam int CBW = $clog2(CHUNK_PIXELS);
  localparam int RW  = 16;
  localparam int REDUCE_STEPS = 3;

  // Wrap a 10-bit coordinate into the store by a short restoring division:
  // the quotient never exceeds seven, so three shifted compare and subtract
  // steps are enough.
  function automatic logic [RW-1:0] reduce(input logic [9:0] v, input logic [RW-1:0] m);
    logic [RW-1:0] t;
    t = RW'(v);
    for (int i = REDUCE_STEPS - 1; i >= 0; i--) begin
      if (t >= (m << i)) begin
        t = t - (m << i);
      end
    end
    reduce = t;
  endfunction

  state_t         state, state_next;
  kind_t          kind_q;
  logic           force_q, check_q;
  logic [XW-1:0]  sx0, sxc, dx0, dxc;
  logic [YW-1:0]  syc, dyc;
  logic [LW-1:0]  w_eff, xx, xo;
  logic [HW-1:0]  h_eff, yy;
  logic [CBW-1:0] c, pend_c;
  logic           row_end;
  logic [15:0]    fill_pix, pix_val;
  logic           pend_v;
  logic [XW-1:0]  pend_x;
  logic [YW-1:0]  pend_y;

  store_ctl_t     sctl;
  logic [XW-1:0]  rx, wx;
  logic [YW-1:0]  ry, wy;
  logic [15:0]    wdata, frame_rdata;
  logic           buf_we, buf_re, load_out;
  logic [15:0]    buf_mem [CHUNK_PIXELS];
  logic [15:0]    buf_rdata;
  logic           x_last, c_last, y_last, copy_wr;
  logic [XW-1:0]  sxc_inc, dxc_inc;
  logic [YW-1:0]  syc_inc, dyc_inc;

  // End-of-run conditions and wrapping increments.
  assign x_last  = (xx == w_eff - LW'(1));
  assign c_last  = (c == CBW'(CHUNK_PIXELS - 1)) || x_last;
  assign y_last  = (yy == h_eff - HW'(1));
  assign sxc_inc = (sxc == XW'(STORE_WIDTH - 1))  ? '0 : sxc + XW'(1);
  assign dxc_inc = (dxc == XW'(STORE_WIDTH - 1))  ? '0 : dxc + XW'(1);
  assign syc_inc = (syc == YW'(STORE_HEIGHT - 1)) ? '0 : syc + YW'(1);
  assign dyc_inc = (dyc == YW'(STORE_HEIGHT - 1)) ? '0 : dyc + YW'(1);

  // A copied pixel lands only where the destination mask allows it.
  assign copy_wr = pend_v && !(check_q && frame_rdata[MASK_BIT]);

  assign in_stall = (state != ST_IDLE);

  vrfc_store #(
    .STORE_WIDTH (STORE_WIDTH),
    .STORE_HEIGHT(STORE_HEIGHT)
  ) u_store (
    .clk    (clk),
    .ctl    (sctl),
    .rd_x   (rx),
    .rd_y   (ry),
    .wr_x   (wx),
    .wr_y   (wy),
    .wr_data(wdata),
    .rd_data(frame_rdata)
  );

  // Next state and memory access selection.
  always_comb begin
    state_next = state;
    sctl       = '0;
    rx         = sxc;
    ry         = syc;
    wx         = dxc;
    wy         = dyc;
    wdata      = fill_pix;
    buf_we     = 1'b0;
    buf_re     = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (kind_t'(kind))
            KIND_FILL: begin
              state_next = (rect_width == '0 || rect_height == '0) ? ST_DONE : ST_FILL;
            end
            KIND_COPY: state_next = ST_CP_RD;
            KIND_READ: state_next = ST_PIX_RD;
            default:   state_next = ST_PIX_WR;
          endcase
        end
      end
      ST_FILL: begin
        sctl.wr = 1'b1;
        if (x_last && y_last) begin
          state_next = ST_DONE;
        end
      end
      ST_CP_RD: begin
        sctl.rd = 1'b1;
        buf_we  = pend_v;
        if (c_last) begin
          state_next = ST_CP_RDW;
        end
      end
      ST_CP_RDW: begin
        buf_we     = pend_v;
        state_next = ST_CP_WR;
      end
      ST_CP_WR: begin
        sctl.rd = 1'b1;
        rx      = dxc;
        ry      = dyc;
        buf_re  = 1'b1;
        sctl.wr = copy_wr;
        wx      = pend_x;
        wy      = pend_y;
        wdata   = buf_rdata | {force_q, 15'd0};
        if (c_last) begin
          state_next = ST_CP_WRW;
        end
      end
      ST_CP_WRW: begin
        sctl.wr    = copy_wr;
        wx         = pend_x;
        wy         = pend_y;
        wdata      = buf_rdata | {force_q, 15'd0};
        state_next = (row_end && y_last) ? ST_DONE : ST_CP_RD;
      end
      ST_PIX_RD: begin
        sctl.rd    = 1'b1;
        state_next = ST_DONE;
      end
      ST_PIX_WR: begin
        sctl.wr    = 1'b1;
        wx         = sxc;
        wy         = syc;
        wdata      = pix_val;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      force_q   <= 1'b0;
      check_q   <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      state  <= state_next;
      pend_v <= (state == ST_CP_RD) || (state == ST_CP_WR);
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        if (cfg_index == CFG_FORCE_MASK) begin
          force_q <= cfg_data;
        end else begin
          check_q <= cfg_data;
        end
      end
    end
  end

  // Chunk buffer: written from the frame store during the read phase and read out during the write phase.
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[pend_c] <= frame_rdata;
    end
    if (buf_re) begin
      buf_rdata <= buf_mem[c];
    end
  end

  // Coordinates, counters and result payload.
  always_ff @(posedge clk) begin
    pend_c <= c;
    pend_x <= dxc;
    pend_y <= dyc;
    if (load_out) begin
      read_value <= (kind_q == KIND_READ) ? frame_rdata : 16'd0;
      op_done    <= 1'b1;
    end
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          kind_q   <= kind_t'(kind);
          sx0      <= XW'(reduce(src_x, RW'(STORE_WIDTH)));
          sxc      <= XW'(reduce(src_x, RW'(STORE_WIDTH)));
          syc      <= YW'(reduce(src_y, RW'(STORE_HEIGHT)));
          dyc      <= YW'(reduce(dst_y, RW'(STORE_HEIGHT)));
          fill_pix <= fill_pixel(fill_color);
          pix_val  <= pixel_value;
          xx       <= '0;
          xo       <= '0;
          yy       <= '0;
          c        <= '0;
          if (kind_t'(kind) == KIND_FILL) begin
            dx0   <= XW'(reduce(dst_x & FILL_ALIGN_MASK, RW'(STORE_WIDTH)));
            dxc   <= XW'(reduce(dst_x & FILL_ALIGN_MASK, RW'(STORE_WIDTH)));
            w_eff <= LW'(({1'b0, rect_width} + FILL_ROUND) & ~FILL_ROUND);
            h_eff <= HW'(rect_height);
          end else begin
            dx0   <= XW'(reduce(dst_x, RW'(STORE_WIDTH)));
            dxc   <= XW'(reduce(dst_x, RW'(STORE_WIDTH)));
            w_eff <= (rect_width == '0) ? LW'(STORE_WIDTH) : LW'(rect_width);
            h_eff <= (rect_height == '0) ? HW'(STORE_HEIGHT) : HW'(rect_height);
          end
        end
      end
      ST_FILL: begin
        if (x_last) begin
          xx  <= '0;
          dxc <= dx0;
          yy  <= yy + HW'(1);
          dyc <= dyc_inc;
        end else begin
          xx  <= xx + LW'(1);
          dxc <= dxc_inc;
        end
      end
      ST_CP_RD: begin
        sxc <= sxc_inc;
        xx  <= xx + LW'(1);
        c   <= c + CBW'(1);
      end
      ST_CP_RDW: begin
        xx <= xo;
        c  <= '0;
      end
      ST_CP_WR: begin
        dxc <= dxc_inc;
        xx  <= xx + LW'(1);
        c   <= c + CBW'(1);
        if (c_last) begin
          row_end <= x_last;
        end
      end
      ST_CP_WRW: begin
        c <= '0;
        if (row_end) begin
          xx  <= '0;
          xo  <= '0;
          sxc <= sx0;
          dxc <= dx0;
          yy  <= yy + HW'(1);
          syc <= syc_inc;
          dyc <= dyc_inc;
        end else begin
          xo <= xx;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // A pending pixel only ever follows an issued copy read.
  a_pend_origin: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> ($past(state) == ST_CP_RD || $past(state) == ST_CP_WR))
    else $error("pending copy pixel without a preceding copy read");

  // The chunk buffer is never filled and drained in the same cycle.
  a_buf_phase: assert property (@(posedge clk) disable iff (rst)
    !(buf_we && buf_re))
    else $error("chunk buffer read and write overlap");

  // A copy write never targets the pixel being read in the same cycle.
  a_store_overlap: assert property (@(posedge clk) disable iff (rst)
    (sctl.rd && sctl.wr) |-> (rx != wx || ry != wy))
    else $error("frame store read and write hit the same pixel");

  // A result is only presented once the operation has finished.
  a_out_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result presented before the operation finished");
`endif

endmodule
